/* hdl/rmr_pkg.sv */
// Shared types, widths and helper functions for the rational multiply-and-reduce block.
package rmr_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int FieldW = 16;
	localparam int OutW = 32;
	localparam int ProdW = 2 * OPERAND_WIDTH;
	localparam int KW = $clog2(ProdW);

	typedef logic signed [FieldW-1:0] field_t;
	typedef logic signed [OutW-1:0] out_t;
	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic [ProdW-1:0] mag_t;

	// Take the low OPERAND_WIDTH bits of a field, sign-extended; wider operands see it unsigned.
	function automatic operand_t ext_operand(input field_t raw);
		logic [OPERAND_WIDTH+FieldW-1:0] z;
		z = (OPERAND_WIDTH + FieldW)'(unsigned'(raw));
		return signed'(z[OPERAND_WIDTH-1:0]);
	endfunction

	// Low output bits of a product-width value.
	function automatic out_t to_out(input prod_t p);
		logic signed [ProdW+OutW-1:0] w;
		w = (ProdW + OutW)'(p);
		return signed'(w[OutW-1:0]);
	endfunction

	function automatic mag_t magnitude(input prod_t p);
		return p[ProdW-1] ? mag_t'(-p) : mag_t'(p);
	endfunction

endpackage

/* hdl/rmr_in_if.sv */
// Operand channel: two signed fractions per transfer.
interface rmr_in_if;
	import rmr_pkg::*;

	logic   valid;
	logic   ready;
	field_t num_a;
	field_t den_a;
	field_t num_b;
	field_t den_b;

	modport source(output valid, output num_a, output den_a, output num_b, output den_b,
		input ready);
	modport sink(input valid, input num_a, input den_a, input num_b, input den_b,
		output ready);
endinterface

/* hdl/rmr_out_if.sv */
// Result channel: one reduced fraction per transfer.
interface rmr_out_if;
	import rmr_pkg::*;

	logic valid;
	logic ready;
	out_t num_out;
	out_t den_out;

	modport source(output valid, output num_out, output den_out, input ready);
	modport sink(input valid, input num_out, input den_out, output ready);
endinterface

/* hdl/rational_multiply_reduce_top.sv */
// Rational multiply with GCD reduction, built around one shared subtractor and a sequencer.
//
// The operands channel carries num_a/den_a and num_b/den_b; one transfer is taken when
// the sequencer is idle. The block forms num_a*num_b and den_a*den_b with one multiplier
// used twice, then, if both products are nonzero, finds their greatest common divisor
// with the binary GCD algorithm and divides both products by it
// with a restoring bit-serial divider. Signs are kept as they come: a negative
// denominator stays negative. A zero product skips reduction entirely.
// A zero product goes straight to the output. Otherwise the result follows the two
// multiplies, the removal of common factors of two, the GCD loop with one subtract or
// shift per cycle, and two divisions of the magnitudes by the GCD; the single subtractor
// serves both the GCD loop and the divisions.
// Items are handled one at a time; operands.ready is high only while idle.
// The finished result sits in an output register, so a new operand transfer can be
// taken while the receiver stalls; a second result then waits in the sequencer until
// the output register frees up. Reset clears the sequencer and the output valid.
module rational_multiply_reduce_top (
	input  logic      clk,
	input  logic      arst_n,
	rmr_in_if.sink    operands,
	rmr_out_if.source result
);
	import rmr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULN,
		S_MULD,
		S_CHECK,
		S_TWOS,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_OUT
	} state_t;

	state_t          state_q;
	operand_t        na_q, da_q, nb_q, db_q;
	prod_t           pn_q, pd_q;
	mag_t            u_q, v_q, g_q, dq_q, rem_q;
	logic [KW-1:0]   k_q, cnt_q;
	out_t            num_red_q, den_red_q;
	out_t            res_num_q, res_den_q;
	logic            res_valid_q;

	operand_t        mul_a, mul_b;
	prod_t           mul_p;
	logic [ProdW:0]  sub_a, sub_b;
	logic [ProdW+1:0] sub_d;
	logic            borrow;
	mag_t            rem_next, dq_next;
	logic            div_last;
	logic            out_free;

	// The single multiplier serves the numerator product, then the denominator product.
	assign mul_a = (state_q == S_MULN) ? na_q : da_q;
	assign mul_b = (state_q == S_MULN) ? nb_q : db_q;
	assign mul_p = mul_a * mul_b;

	// The shared subtractor: GCD compare/subtract, or a restoring divide step.
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			S_GCD: begin
				sub_a = {1'b0, u_q};
				sub_b = {1'b0, v_q};
			end
			S_DIVN, S_DIVD: begin
				sub_a = {rem_q, dq_q[ProdW-1]};
				sub_b = {1'b0, g_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow   = sub_d[ProdW+1];
	assign rem_next = borrow ? sub_a[ProdW-1:0] : sub_d[ProdW-1:0];
	assign dq_next  = {dq_q[ProdW-2:0], ~borrow};
	assign div_last = (cnt_q == KW'(ProdW - 1));
	assign out_free = !res_valid_q || result.ready;

	assign operands.ready = (state_q == S_IDLE);
	assign result.valid   = res_valid_q;
	assign result.num_out = res_num_q;
	assign result.den_out = res_den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			na_q        <= '0;
			da_q        <= '0;
			nb_q        <= '0;
			db_q        <= '0;
			pn_q        <= '0;
			pd_q        <= '0;
			u_q         <= '0;
			v_q         <= '0;
			g_q         <= '0;
			dq_q        <= '0;
			rem_q       <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			num_red_q   <= '0;
			den_red_q   <= '0;
			res_num_q   <= '0;
			res_den_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The output register loads a finished result, or empties on a transfer.
			if (state_q == S_OUT && out_free) begin
				res_num_q   <= num_red_q;
				res_den_q   <= den_red_q;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (operands.valid) begin
						na_q    <= ext_operand(operands.num_a);
						da_q    <= ext_operand(operands.den_a);
						nb_q    <= ext_operand(operands.num_b);
						db_q    <= ext_operand(operands.den_b);
						state_q <= S_MULN;
					end
				end
				S_MULN: begin
					pn_q    <= mul_p;
					state_q <= S_MULD;
				end
				S_MULD: begin
					pd_q    <= mul_p;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (pn_q == '0 || pd_q == '0) begin
						num_red_q <= to_out(pn_q);
						den_red_q <= to_out(pd_q);
						state_q   <= S_OUT;
					end else begin
						u_q     <= magnitude(pn_q);
						v_q     <= magnitude(pd_q);
						k_q     <= '0;
						state_q <= S_TWOS;
					end
				end
				S_TWOS: begin
					// Strip common factors of two; they are restored when the GCD is formed.
					if (u_q[0] || v_q[0]) begin
						state_q <= S_GCD;
					end else begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + KW'(1);
					end
				end
				S_GCD: begin
					if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (sub_d == '0) begin
						g_q     <= u_q << k_q;
						dq_q    <= magnitude(pn_q);
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIVN;
					end else if (!borrow) begin
						u_q <= sub_d[ProdW-1:0];
					end else begin
						// v - u is the negated difference.
						v_q <= mag_t'(~sub_d[ProdW-1:0]) + mag_t'(1);
					end
				end
				S_DIVN: begin
					if (div_last) begin
						num_red_q <= to_out(pn_q[ProdW-1] ? -prod_t'(dq_next) : prod_t'(dq_next));
						dq_q      <= magnitude(pd_q);
						rem_q     <= '0;
						cnt_q     <= '0;
						state_q   <= S_DIVD;
					end else begin
						rem_q <= rem_next;
						dq_q  <= dq_next;
						cnt_q <= cnt_q + KW'(1);
					end
				end
				S_DIVD: begin
					rem_q <= rem_next;
					dq_q  <= dq_next;
					cnt_q <= cnt_q + KW'(1);
					if (div_last) begin
						den_red_q <= to_out(pd_q[ProdW-1] ? -prod_t'(dq_next) : prod_t'(dq_next));
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Neither GCD operand may reach zero while the loop runs.
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GCD |-> (u_q != '0 && v_q != '0))
		else $error("GCD operand reached zero");

	// Dividing by the GCD must leave no remainder.
	a_exact_div: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIVN || state_q == S_DIVD) && div_last) |-> rem_next == '0)
		else $error("division by GCD left a remainder");

	// After an operand transfer the sequencer is busy.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(operands.valid && operands.ready) |=> !operands.ready)
		else $error("operands taken twice in a row");

	// Leaving the output state always presents a result.
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> result.valid)
		else $error("result not presented");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the rational multiply-and-reduce block.
`timescale 1ns / 100ps

module tb;
	import rmr_pkg::*;

	// One reduced fraction as it leaves the block.
	typedef struct packed {
		out_t num;
		out_t den;
	} fraction_t;

	localparam int HalfPeriod = 5;
	localparam int ResetCycles = 6;
	// Watch time after the last expected result; leave room above the longest reduction.
	localparam int DrainCycles = 300;
	// Receiver hold-off for the back-pressure test, well beyond one reduction.
	localparam int HoldOffCycles = 600;
	localparam int RandomItems = 610;
	localparam int SteadyItems = 60;
	localparam int ReportLimit = 10;

	logic clk;
	logic arst_n;

	rmr_in_if  operands();
	rmr_out_if result();

	rational_multiply_reduce_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operands(operands.sink),
		.result  (result.source)
	);

	// Products still on their way through the block, oldest first.
	fraction_t pending_products[$];
	int unsigned mismatches = 0;
	bit sender_idles = 0;
	bit receiver_idles = 0;
	bit hold_off_request = 0;

	always #(HalfPeriod) clk = ~clk;

	// Value of a field as the block sees it: its low OPERAND_WIDTH bits, sign-extended.
	// A field narrower than the operand is taken unsigned, as the package does.
	function automatic longint operand_value(input field_t raw);
		longint unsigned v;
		v = 0;
		v[FieldW-1:0] = raw;
		v = v & ((64'd1 << OPERAND_WIDTH) - 64'd1);
		if (v[OPERAND_WIDTH-1]) begin
			return longint'(v) - (longint'(1) << OPERAND_WIDTH);
		end
		return longint'(v);
	endfunction

	// Product of two fractions, reduced by the gcd of the two products unless one is zero.
	function automatic fraction_t reduced_product(input field_t na, input field_t da,
			input field_t nb, input field_t db);
		longint pn;
		longint pd;
		longint unsigned x;
		longint unsigned y;
		longint unsigned r;
		fraction_t f;
		pn = operand_value(na) * operand_value(nb);
		pd = operand_value(da) * operand_value(db);
		if (pn != 0 && pd != 0) begin
			x = (pn < 0) ? longint'(-pn) : pn;
			y = (pd < 0) ? longint'(-pd) : pd;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			pn = pn / longint'(x);
			pd = pd / longint'(x);
		end
		f.num = pn[OutW-1:0];
		f.den = pd[OutW-1:0];
		return f;
	endfunction

	task automatic report_mismatch(input string what, input out_t want, input out_t got);
		mismatches++;
		if (mismatches <= ReportLimit) begin
			$display("%0t: %s expected %0d (0x%h) got %0d (0x%h)", $realtime, what,
				want, want, got, got);
		end
	endtask

	// Offers one pair of fractions and returns once the transfer has taken place.
	// Valid stays high on return, so back-to-back items never drop it in between;
	// it only goes low for an idle burst or at the end of the stimulus.
	task automatic send_pair(input field_t na, input field_t da, input field_t nb,
			input field_t db);
		@(negedge clk);
		if (sender_idles && $urandom_range(0, 2) == 0) begin
			operands.valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		operands.valid = 1'b1;
		operands.num_a = na;
		operands.den_a = da;
		operands.num_b = nb;
		operands.den_b = db;
		do @(posedge clk); while (!operands.ready);
		pending_products.push_back(reduced_product(na, da, nb, db));
	endtask

	// Mixes full-range values, small values, values rich in factors of two and extremes,
	// so that the gcd ranges from one up to large powers of two and common odd factors.
	function automatic field_t random_field();
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return field_t'($urandom_range(0, 65535));
			4, 5: return field_t'($urandom_range(0, 80) - 40);
			6, 7: begin
				s = $urandom_range(0, 30) - 15;
				return field_t'(s <<< $urandom_range(0, 11));
			end
			8: begin
				case ($urandom_range(0, 4))
					0: return field_t'(-32768);
					1: return field_t'(32767);
					2: return field_t'(-1);
					3: return field_t'(0);
					default: return field_t'(1);
				endcase
			end
			default: return field_t'(1);
		endcase
	endfunction

	task automatic send_random_pair();
		field_t na;
		field_t da;
		field_t nb;
		field_t db;
		field_t k;
		na = random_field();
		da = random_field();
		nb = random_field();
		db = random_field();
		case ($urandom_range(0, 5))
			// Fraction times an integer factor.
			0: db = field_t'(1);
			// Numerator and denominator share a factor, so reduction does real work.
			1: begin
				k = field_t'($urandom_range(2, 60));
				na = field_t'(int'(na) % 500 * int'(k));
				db = field_t'(int'(db) % 500 * int'(k));
			end
			default: ;
		endcase
		send_pair(na, da, nb, db);
	endtask

	// Extremes of every field, zero products, zero denominators, the most negative
	// operands, integer factors and negative denominators.
	task automatic test_directed();
		send_pair(16'sd0, 16'sd1, 16'sd5, 16'sd1);
		send_pair(16'sd3, 16'sd0, 16'sd4, 16'sd7);
		send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_pair(16'sd1, 16'sd0, 16'sd1, 16'sd0);
		send_pair(field_t'(0), field_t'(-32768), field_t'(0), field_t'(32767));
		send_pair(field_t'(-32768), field_t'(-32768), field_t'(-32768), field_t'(-32768));
		send_pair(field_t'(-32768), field_t'(1), field_t'(-32768), field_t'(1));
		send_pair(field_t'(32767), field_t'(32767), field_t'(32767), field_t'(32767));
		send_pair(field_t'(32767), field_t'(-32768), field_t'(-32768), field_t'(32767));
		send_pair(field_t'(32767), field_t'(1), field_t'(-32768), field_t'(1));
		send_pair(field_t'(1), field_t'(32767), field_t'(1), field_t'(-32768));
		send_pair(field_t'(-32768), field_t'(32767), field_t'(0), field_t'(5));
		send_pair(16'sd6, 16'sd4, 16'sd10, 16'sd15);
		send_pair(16'sd3, -16'sd4, 16'sd5, 16'sd1);
		send_pair(-16'sd7, 16'sd9, 16'sd2, 16'sd1);
		send_pair(16'sd12, 16'sd35, 16'sd10, 16'sd21);
		send_pair(16'sd1, -16'sd1, -16'sd1, 16'sd1);
		send_pair(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
		send_pair(16'sd2, 16'sd3, 16'sd5, 16'sd7);
		send_pair(16'sd4096, 16'sd2048, -16'sd8192, 16'sd1024);
		send_pair(field_t'(-1), field_t'(-32768), field_t'(32767), field_t'(-1));
	endtask

	// Random items, with idling switched on and off in stretches on both sides.
	task automatic test_random();
		for (int i = 0; i < RandomItems; i++) begin
			if (i % 50 == 0) begin
				sender_idles = ($urandom_range(0, 3) != 0);
				receiver_idles = ($urandom_range(0, 3) != 0);
			end
			send_random_pair();
		end
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the output
	// register and then the sequencer fill up and the operand channel stalls.
	task automatic test_back_pressure();
		sender_idles = 0;
		receiver_idles = 0;
		hold_off_request = 1;
		for (int i = 0; i < 8; i++) begin
			send_random_pair();
		end
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_steady_stream();
		sender_idles = 0;
		receiver_idles = 0;
		for (int i = 0; i < SteadyItems; i++) begin
			send_random_pair();
		end
		@(negedge clk);
		operands.valid = 1'b0;
	endtask

	// Receiver: ready with random idle bursts, or one long hold-off when requested.
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				result.ready = 1'b0;
				for (int n = 1; n < HoldOffCycles; n++) begin
					@(negedge clk);
				end
				hold_off_request = 0;
			end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
				result.ready = 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				result.ready = 1'b1;
			end
		end
	end

	// Every result transfer is compared with the oldest outstanding product.
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_products.size() == 0) begin
				report_mismatch("unexpected result, num_out", out_t'(0), result.num_out);
			end else begin
				want = pending_products.pop_front();
				if (result.num_out !== want.num) begin
					report_mismatch("num_out", want.num, result.num_out);
				end
				if (result.den_out !== want.den) begin
					report_mismatch("den_out", want.den, result.den_out);
				end
			end
		end
	end

	// Main sequence: reset once, run each test in turn, drain, and give the verdict.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		operands.valid = 1'b0;
		operands.num_a = '0;
		operands.den_a = '0;
		operands.num_b = '0;
		operands.den_b = '0;
		repeat (ResetCycles) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();
		test_back_pressure();
		test_steady_stream();

		// Wait for every outstanding product, then watch a while for stray results.
		while (pending_products.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0 && pending_products.size() == 0) begin
			$display("rational_multiply_reduce_top: match");
		end else begin
			$display("rational_multiply_reduce_top: mismatch");
		end
		$finish;
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#10_000_000;
		$display("rational_multiply_reduce_top: mismatch");
		$finish;
	end

endmodule
